/* hdl/eahm_pkg.sv */
// ============================================================================
// eahm_pkg: shared types and constants
// Payload types of the input and result channels, trig series constants and
// the latency of the sine/cosine pipeline.
// ============================================================================
`default_nettype none

package eahm_pkg;

  typedef struct packed {
    logic signed [15:0] angle_theta;
    logic signed [15:0] angle_psi;
    logic signed [15:0] angle_phi;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  // Angle units of 1/64 degree.
  localparam logic signed [17:0] FULL_TURN    = 18'sd23040;
  localparam logic [14:0]        QUARTER_TURN = 15'd5760;
  localparam logic [14:0]        HALF_TURN    = 15'd11520;
  localparam logic [14:0]        THREE_QUARTER_TURN = 15'd17280;
  localparam logic [12:0]        EIGHTH_TURN  = 13'd2880;

  // pi/11520 in Q50.
  localparam logic [38:0] RAD_PER_UNIT = 39'd307041569098;

  localparam int NUM_STEPS = 7;
  localparam int SIN_STEPS = 6;

  // Stages: reduction (2), radians (1), square (1), three per series step, finish (2).
  localparam int SC_LAT = 4 + 3 * NUM_STEPS + 2;

  function automatic logic [7:0] sin_div(input int k);
    unique case (k)
      0: return 8'd156;
      1: return 8'd110;
      2: return 8'd72;
      3: return 8'd42;
      4: return 8'd20;
      5: return 8'd6;
      default: return 8'd2;
    endcase
  endfunction

  function automatic logic [7:0] cos_div(input int k);
    unique case (k)
      0: return 8'd182;
      1: return 8'd132;
      2: return 8'd90;
      3: return 8'd56;
      4: return 8'd30;
      5: return 8'd12;
      default: return 8'd2;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/eahm_chan_if.sv */
// ============================================================================
// eahm_chan_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising edge.
// ============================================================================
`default_nettype none

interface eahm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/eahm_sincos.sv */
// ============================================================================
// eahm_sincos: pipelined sine and cosine of an angle
// Reduces the angle to an octant, converts to radians and evaluates nested
// Taylor series in Q30, one series step per three stages.
// ============================================================================
`default_nettype none

module eahm_sincos (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] angle,
  output logic signed [31:0]      sin_q30,
  output logic signed [31:0]      cos_q30
);

  typedef struct packed {
    logic [29:0] r;
    logic [29:0] r2;
    logic [1:0]  q;
    logic        swap;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] ts;
    logic [30:0] tc;
  } bnd_t;

  localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

  // Stage 1: modulo one turn.
  logic signed [17:0] ax;
  logic signed [17:0] am;
  logic [14:0]        m_r;

  always_comb begin
    ax = {{2{angle[15]}}, angle};
    am = ax;
    if (ax < 0) begin
      am = ax + eahm_pkg::FULL_TURN;
      if (am < 0) begin
        am = am + eahm_pkg::FULL_TURN;
      end
    end else if (ax >= eahm_pkg::FULL_TURN) begin
      am = ax - eahm_pkg::FULL_TURN;
    end
  end

  // Stage 2: quadrant and octant fold.
  logic [1:0]  q_c;
  logic [12:0] x_c;
  logic [11:0] y_r;
  logic [1:0]  q2_r;
  logic        swap2_r;

  always_comb begin
    priority if (m_r < eahm_pkg::QUARTER_TURN) begin
      q_c = 2'd0;
      x_c = m_r[12:0];
    end else if (m_r < eahm_pkg::HALF_TURN) begin
      q_c = 2'd1;
      x_c = 13'(m_r - eahm_pkg::QUARTER_TURN);
    end else if (m_r < eahm_pkg::THREE_QUARTER_TURN) begin
      q_c = 2'd2;
      x_c = 13'(m_r - eahm_pkg::HALF_TURN);
    end else begin
      q_c = 2'd3;
      x_c = 13'(m_r - eahm_pkg::THREE_QUARTER_TURN);
    end
  end

  // Stage 3: radians in Q30. Stage 4: square.
  logic [51:0] rp;
  logic [29:0] r3_r;
  logic [1:0]  q3_r;
  logic        swap3_r;
  logic [60:0] r2p;

  assign rp  = 52'(y_r) * 52'(eahm_pkg::RAD_PER_UNIT) + (52'd1 << 19);
  assign r2p = 61'(r3_r) * 61'(r3_r) + (61'd1 << 29);

  bnd_t bnd_r [0:eahm_pkg::NUM_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= am[14:0];
      q2_r    <= q_c;
      swap2_r <= (x_c > eahm_pkg::EIGHTH_TURN);
      y_r     <= (x_c > eahm_pkg::EIGHTH_TURN) ?
                 12'(13'(eahm_pkg::QUARTER_TURN) - x_c) : x_c[11:0];
      r3_r    <= rp[49:20];
      q3_r    <= q2_r;
      swap3_r <= swap2_r;
      bnd_r[0].side.r    <= r3_r;
      bnd_r[0].side.r2   <= r2p[59:30];
      bnd_r[0].side.q    <= q3_r;
      bnd_r[0].side.swap <= swap3_r;
      bnd_r[0].ts        <= ONE_Q30;
      bnd_r[0].tc        <= ONE_Q30;
    end
  end

  // Series steps: t = 1 - floor(r2 * t / d), the division done as a
  // reciprocal multiply that may fall one short, then a remainder fix.
  for (genvar k = 0; k < eahm_pkg::NUM_STEPS; k++) begin : g_step
    localparam logic [7:0]  DS = eahm_pkg::sin_div(k);
    localparam logic [7:0]  DC = eahm_pkg::cos_div(k);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
    localparam bit          SIN_ON = (k < eahm_pkg::SIN_STEPS);

    logic [60:0] ps_c, pc_c;
    logic [61:0] qms_c, qmc_c;
    logic [29:0] rems_c, remc_c;
    logic [29:0] qs_c, qc_c;

    bnd_t        a_r, b_r;
    logic [29:0] va_s_r, va_c_r, vb_s_r, vb_c_r;
    logic [29:0] qe_s_r, qe_c_r;

    assign ps_c  = 61'(bnd_r[k].side.r2) * 61'(bnd_r[k].ts);
    assign pc_c  = 61'(bnd_r[k].side.r2) * 61'(bnd_r[k].tc);
    assign qms_c = 62'(va_s_r) * 62'(MS);
    assign qmc_c = 62'(va_c_r) * 62'(MC);
    assign rems_c = vb_s_r - 30'(qe_s_r * 30'(DS));
    assign remc_c = vb_c_r - 30'(qe_c_r * 30'(DC));
    assign qs_c  = qe_s_r + 30'(rems_c >= 30'(DS));
    assign qc_c  = qe_c_r + 30'(remc_c >= 30'(DC));

    always_ff @(posedge clk) begin
      if (en) begin
        a_r    <= bnd_r[k];
        va_s_r <= ps_c[59:30];
        va_c_r <= pc_c[59:30];
        b_r    <= a_r;
        vb_s_r <= va_s_r;
        vb_c_r <= va_c_r;
        qe_s_r <= qms_c[61:32];
        qe_c_r <= qmc_c[61:32];
        bnd_r[k+1].side <= b_r.side;
        bnd_r[k+1].ts   <= SIN_ON ? (ONE_Q30 - 31'(qs_c)) : b_r.ts;
        bnd_r[k+1].tc   <= ONE_Q30 - 31'(qc_c);
      end
    end
  end

  // Finish sine, then unfold octant and quadrant.
  localparam int LAST = eahm_pkg::NUM_STEPS;

  logic [60:0] sp_c;
  logic [30:0] ps_r, pc_r;
  logic [1:0]  qf_r;
  logic        swapf_r;
  logic signed [31:0] sv, cv;

  assign sp_c = 61'(bnd_r[LAST].side.r) * 61'(bnd_r[LAST].ts) + (61'd1 << 29);
  assign sv   = swapf_r ? 32'(pc_r) : 32'(ps_r);
  assign cv   = swapf_r ? 32'(ps_r) : 32'(pc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r    <= sp_c[60:30];
      pc_r    <= bnd_r[LAST].tc;
      qf_r    <= bnd_r[LAST].side.q;
      swapf_r <= bnd_r[LAST].side.swap;
      unique case (qf_r)
        2'd0: begin sin_q30 <= sv;  cos_q30 <= cv;  end
        2'd1: begin sin_q30 <= cv;  cos_q30 <= -sv; end
        2'd2: begin sin_q30 <= -sv; cos_q30 <= -cv; end
        2'd3: begin sin_q30 <= -cv; cos_q30 <= sv;  end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/euler_angles_to_homogeneous_matrix_top.sv */
// ============================================================================
// euler_angles_to_homogeneous_matrix_top: Z-Y-Z Euler rotation matrix
// Computes the nine rotation entries of a homogeneous transform from three
// angles and passes the translation through.
// ============================================================================
//
//   channel  | dir | handshake           | beat contents
//   ---------+-----+---------------------+--------------------------------
//   in_ch    | in  | valid/ready         | three angles, translation
//   out_ch   | out | valid/ready         | nine entries, translation
//
// One beat is accepted per cycle while the skid register is empty; a beat
// passes through the sine/cosine pipelines, the first and triple products,
// the sums, the rounding stage and the output register.
// The sine/cosine series steps, three stages each, make up most of the depth.
// The whole pipeline advances together; a skid register behind the output
// register keeps input ready high while one result waits.
// Reset clears the valid bits only.
`default_nettype none

module euler_angles_to_homogeneous_matrix_top #(
  parameter int ENTRY_FRAC_BITS = 14
) (
  input wire logic  clk,
  input wire logic  rst_n,
  eahm_chan_if.sink   in_ch,
  eahm_chan_if.source out_ch
);

  localparam int TOT = eahm_pkg::SC_LAT + 4;
  localparam int SH  = 30 - ENTRY_FRAC_BITS;
  localparam logic [34:0] RND = (SH > 0) ? (35'd1 << (SH - 1)) : 35'd0;
  localparam logic [34:0] LIM = 35'd1 << ENTRY_FRAC_BITS;
  localparam int LIM_I = 1 << ENTRY_FRAC_BITS;

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic [31:0] ua, ub;
    logic [63:0] u;
    ua = a[31] ? 32'(-a) : 32'(a);
    ub = b[31] ? 32'(-b) : 32'(b);
    u  = 64'(ua) * 64'(ub) + (64'd1 << 29);
    return (a[31] != b[31]) ? -$signed(u[61:30]) : $signed(u[61:30]);
  endfunction

  function automatic logic [15:0] entry_out(input logic signed [33:0] v);
    logic [34:0] u;
    logic [34:0] n;
    u = v[33] ? 35'(-v) : 35'(v);
    u = (u + RND) >> SH;
    if (u > LIM) begin
      u = LIM;
    end
    n = v[33] ? (35'd0 - u) : u;
    return n[15:0];
  endfunction

  logic en;
  logic out_v_r, skid_v_r;
  eahm_pkg::out_item_t out_r, skid_r, pitem;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // Valid bits and translation ride alongside the arithmetic.
  logic [TOT-1:0] vld_r;
  logic signed [31:0] sx_r [0:TOT-1];
  logic signed [31:0] sy_r [0:TOT-1];
  logic signed [31:0] sz_r [0:TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0] <= in_ch.data.shift_x;
      sy_r[0] <= in_ch.data.shift_y;
      sz_r[0] <= in_ch.data.shift_z;
      for (int i = 1; i < TOT; i++) begin
        sx_r[i] <= sx_r[i-1];
        sy_r[i] <= sy_r[i-1];
        sz_r[i] <= sz_r[i-1];
      end
    end
  end

  logic signed [31:0] st, ct, sp, cp, sf, cf;

  eahm_sincos u_sc_theta (.clk(clk), .en(en), .angle(in_ch.data.angle_theta),
                          .sin_q30(st), .cos_q30(ct));
  eahm_sincos u_sc_psi   (.clk(clk), .en(en), .angle(in_ch.data.angle_psi),
                          .sin_q30(sp), .cos_q30(cp));
  eahm_sincos u_sc_phi   (.clk(clk), .en(en), .angle(in_ch.data.angle_phi),
                          .sin_q30(sf), .cos_q30(cf));

  // First products.
  logic signed [31:0] cfcp_r, sfcp_r, sfst_r, sfct_r, cfsp_r, cfst_r, cfct_r;
  logic signed [31:0] sfsp_r, spct_r, spst_r, ct1_r, st1_r, cp1_r;
  // Triple products.
  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic signed [31:0] sfst2_r, sfct2_r, cfsp2_r, cfst2_r, cfct2_r;
  logic signed [31:0] sfsp2_r, spct2_r, spst2_r, cp2_r;
  // Sums in Q30.
  logic signed [33:0] e_r [0:8];
  logic [15:0] m_r [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      cfcp_r <= mulq(cf, cp);
      sfcp_r <= mulq(sf, cp);
      sfst_r <= mulq(sf, st);
      sfct_r <= mulq(sf, ct);
      cfsp_r <= mulq(cf, sp);
      cfst_r <= mulq(cf, st);
      cfct_r <= mulq(cf, ct);
      sfsp_r <= mulq(sf, sp);
      spct_r <= mulq(sp, ct);
      spst_r <= mulq(sp, st);
      ct1_r  <= ct;
      st1_r  <= st;
      cp1_r  <= cp;

      a_r     <= mulq(cfcp_r, ct1_r);
      b_r     <= mulq(cfcp_r, st1_r);
      c_r     <= mulq(sfcp_r, ct1_r);
      d_r     <= mulq(sfcp_r, st1_r);
      sfst2_r <= sfst_r;
      sfct2_r <= sfct_r;
      cfsp2_r <= cfsp_r;
      cfst2_r <= cfst_r;
      cfct2_r <= cfct_r;
      sfsp2_r <= sfsp_r;
      spct2_r <= spct_r;
      spst2_r <= spst_r;
      cp2_r   <= cp1_r;

      e_r[0] <= 34'(a_r) - 34'(sfst2_r);
      e_r[1] <= 34'(b_r) + 34'(sfct2_r);
      e_r[2] <= -34'(cfsp2_r);
      e_r[3] <= -34'(c_r) - 34'(cfst2_r);
      e_r[4] <= -34'(d_r) + 34'(cfct2_r);
      e_r[5] <= 34'(sfsp2_r);
      e_r[6] <= 34'(spct2_r);
      e_r[7] <= 34'(spst2_r);
      e_r[8] <= 34'(cp2_r);

      for (int i = 0; i < 9; i++) begin
        m_r[i] <= entry_out(e_r[i]);
      end
    end
  end

  always_comb begin
    pitem.m00   = m_r[0];
    pitem.m01   = m_r[1];
    pitem.m02   = m_r[2];
    pitem.m10   = m_r[3];
    pitem.m11   = m_r[4];
    pitem.m12   = m_r[5];
    pitem.m20   = m_r[6];
    pitem.m21   = m_r[7];
    pitem.m22   = m_r[8];
    pitem.out_x = sx_r[TOT-1];
    pitem.out_y = sy_r[TOT-1];
    pitem.out_z = sz_r[TOT-1];
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= vld_r[TOT-1];
      end
    end else if (vld_r[TOT-1] && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : pitem;
    end else if (!skid_v_r) begin
      skid_r <= pitem;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready && vld_r[TOT-1]))
    else $error("skid register filled without a stalled output");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (ENTRY_FRAC_BITS <= 14) |->
      (int'($signed(out_r.m22)) <= LIM_I) && (int'($signed(out_r.m22)) >= -LIM_I))
    else $error("rotation entry outside plus or minus one");
`endif

endmodule

`default_nettype wire
